FILE: sv/gbba_pkg.sv
package gbba_pkg;

    localparam int GROUPS         = 8;
    localparam int BITS_PER_GROUP = 8192;
    localparam int CAPACITY       = GROUPS * BITS_PER_GROUP;

    localparam int FIELD_W   = 17;
    localparam int WORD_BITS = 64;
    localparam int BIT_AW    = $clog2(WORD_BITS);
    localparam int WORDS     = CAPACITY / WORD_BITS;
    localparam int WORD_AW   = $clog2(WORDS);
    localparam int SUM_WORDS = WORDS / WORD_BITS;
    localparam int SUM_AW    = $clog2(SUM_WORDS);

    localparam logic [FIELD_W-1:0] CAP_BLOCKS       = FIELD_W'(CAPACITY);
    localparam logic [FIELD_W-1:0] TOTAL_BLOCKS_RST = FIELD_W'(65536);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOT_USED = 2'd3
    } t_status;

    typedef struct packed {
        logic              found;
        logic [BIT_AW-1:0] idx;
    } t_zero;

    function automatic t_zero first_zero(input logic [WORD_BITS-1:0] w);
        t_zero z;
        z.found = 1'b0;
        z.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                z.found = 1'b1;
                z.idx   = BIT_AW'(i);
            end
        end
        return z;
    endfunction

endpackage

FILE: sv/gbba_ram.sv
module gbba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/group_bitmap_block_allocator.sv
// Block allocator over a used-bit map of 65536 blocks, kept in a 1024 x 64 RAM,
// with a 16 x 64 summary RAM that marks every completely used map word. An
// allocate transaction scans the summary for the first word with a clear bit
// (up to 16 words, one at a time), reads that map word and takes its lowest
// clear bit below total_blocks. A free transaction reads, checks and rewrites
// one map word and its summary word, and skips the map access when the number
// is out of range. One transaction is in flight at a time; a finished response
// waits in the output register while the next request is taken. After reset a
// clearing pass writes zeros through all 1024 map words before the first
// request is accepted. Configuration writes to total_blocks are taken at once
// and must only occur while idle.
module group_bitmap_block_allocator
    import gbba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FIELD_W-1:0] i_cfg_data,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  logic               i_req_kind,
    input  logic [FIELD_W-1:0] i_req_block_number,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output logic [1:0]         o_rsp_status,
    output logic [FIELD_W-1:0] o_rsp_granted_block,
    output logic [FIELD_W-1:0] o_rsp_free_total
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SUM_RD,
        S_SUM_CHK,
        S_MAP_RD,
        S_MAP_CHK,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [WORD_AW-1:0]   r_clr_addr;
    logic [FIELD_W-1:0]   r_total_blocks;
    logic [FIELD_W-1:0]   r_used;
    logic                 r_kind;
    logic [SUM_AW-1:0]    r_sidx;
    logic [WORD_AW-1:0]   r_word;
    logic [BIT_AW-1:0]    r_bit;
    t_status              r_res_status;
    logic [FIELD_W-1:0]   r_res_granted;
    logic                 r_rsp_valid;
    t_status              r_rsp_status;
    logic [FIELD_W-1:0]   r_rsp_granted;
    logic [FIELD_W-1:0]   r_rsp_free;

    logic [FIELD_W-1:0]   lim;
    logic [FIELD_W-1:0]   diff;
    logic [FIELD_W-1:0]   req_idx;
    logic [WORD_BITS-1:0] word_mask;
    logic [WORD_BITS-1:0] set_word;
    logic [WORD_BITS-1:0] clr_word;
    logic [WORD_AW-1:0]   cand_word;
    t_zero                sum_zero;
    t_zero                map_zero;

    logic                 map_we;
    logic [WORD_AW-1:0]   map_waddr;
    logic [WORD_BITS-1:0] map_wdata;
    logic [WORD_AW-1:0]   map_raddr;
    logic [WORD_BITS-1:0] map_rdata;
    logic                 sum_we;
    logic [SUM_AW-1:0]    sum_waddr;
    logic [WORD_BITS-1:0] sum_wdata;
    logic [SUM_AW-1:0]    sum_raddr;
    logic [WORD_BITS-1:0] sum_rdata;

    gbba_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    gbba_ram #(.WIDTH(WORD_BITS), .DEPTH(SUM_WORDS)) u_sum (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    always_comb begin
        lim       = (r_total_blocks > CAP_BLOCKS) ? CAP_BLOCKS : r_total_blocks;
        req_idx   = i_req_block_number - FIELD_W'(1);
        sum_zero  = first_zero(sum_rdata);
        cand_word = {r_sidx, sum_zero.idx};
        diff      = lim - {1'b0, r_word, BIT_AW'(0)};
        word_mask = (diff >= FIELD_W'(WORD_BITS)) ? '0 :
                    ~((WORD_BITS'(1) << diff[BIT_AW-1:0]) - WORD_BITS'(1));
        map_zero  = first_zero(map_rdata | word_mask);
        set_word  = map_rdata | (WORD_BITS'(1) << map_zero.idx);
        clr_word  = map_rdata & ~(WORD_BITS'(1) << r_bit);

        map_we    = 1'b0;
        map_waddr = r_word;
        map_wdata = '0;
        map_raddr = r_word;
        sum_we    = 1'b0;
        sum_waddr = r_word[WORD_AW-1:BIT_AW];
        sum_wdata = '0;
        sum_raddr = r_sidx;

        unique case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr_addr;
                sum_we    = 1'b1;
                sum_waddr = r_clr_addr[SUM_AW-1:0];
            end
            S_MAP_RD: begin
                sum_raddr = r_word[WORD_AW-1:BIT_AW];
            end
            S_MAP_CHK: begin
                if (r_kind == KIND_ALLOC) begin
                    if (map_zero.found) begin
                        map_we    = 1'b1;
                        map_wdata = set_word;
                        sum_we    = &set_word;
                        sum_wdata = sum_rdata | (WORD_BITS'(1) << r_word[BIT_AW-1:0]);
                    end
                end else if (map_rdata[r_bit]) begin
                    map_we    = 1'b1;
                    map_wdata = clr_word;
                    sum_we    = 1'b1;
                    sum_wdata = sum_rdata & ~(WORD_BITS'(1) << r_word[BIT_AW-1:0]);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_total_blocks <= TOTAL_BLOCKS_RST;
            r_used         <= '0;
            r_rsp_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_total_blocks <= i_cfg_data;
            end
            if (r_rsp_valid && i_rsp_ready && r_state != S_DONE) begin
                r_rsp_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + WORD_AW'(1);
                    if (r_clr_addr == WORD_AW'(WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_kind        <= i_req_kind;
                        r_sidx        <= '0;
                        r_res_granted <= '0;
                        r_word        <= req_idx[BIT_AW+WORD_AW-1:BIT_AW];
                        r_bit         <= req_idx[BIT_AW-1:0];
                        if (i_req_kind == KIND_ALLOC) begin
                            r_state <= S_SUM_RD;
                        end else if (i_req_block_number == '0 || i_req_block_number > lim) begin
                            r_res_status <= ST_RANGE;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_MAP_RD;
                        end
                    end
                end
                S_SUM_RD: begin
                    r_state <= S_SUM_CHK;
                end
                S_SUM_CHK: begin
                    if (sum_zero.found) begin
                        r_word <= cand_word;
                        if ({1'b0, cand_word, BIT_AW'(0)} >= lim) begin
                            r_res_status <= ST_NO_SPACE;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_MAP_RD;
                        end
                    end else if (r_sidx == SUM_AW'(SUM_WORDS - 1)) begin
                        r_res_status <= ST_NO_SPACE;
                        r_state      <= S_DONE;
                    end else begin
                        r_sidx  <= r_sidx + SUM_AW'(1);
                        r_state <= S_SUM_RD;
                    end
                end
                S_MAP_RD: begin
                    r_state <= S_MAP_CHK;
                end
                S_MAP_CHK: begin
                    r_state <= S_DONE;
                    if (r_kind == KIND_ALLOC) begin
                        if (map_zero.found) begin
                            r_res_status  <= ST_OK;
                            r_res_granted <= {1'b0, r_word, map_zero.idx} + FIELD_W'(1);
                            r_used        <= r_used + FIELD_W'(1);
                        end else begin
                            r_res_status <= ST_NO_SPACE;
                        end
                    end else if (map_rdata[r_bit]) begin
                        r_res_status <= ST_OK;
                        if (r_used != '0) begin
                            r_used <= r_used - FIELD_W'(1);
                        end
                    end else begin
                        r_res_status <= ST_NOT_USED;
                    end
                end
                S_DONE: begin
                    if (!r_rsp_valid || i_rsp_ready) begin
                        r_rsp_valid   <= 1'b1;
                        r_rsp_status  <= r_res_status;
                        r_rsp_granted <= r_res_granted;
                        r_rsp_free    <= (r_used >= lim) ? '0 : lim - r_used;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready         = (r_state == S_IDLE);
    assign o_rsp_valid         = r_rsp_valid;
    assign o_rsp_status        = r_rsp_status;
    assign o_rsp_granted_block = r_rsp_granted;
    assign o_rsp_free_total    = r_rsp_free;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CAP_BLOCKS)
        else $error("used count beyond capacity");

    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp_status != ST_OK) |-> o_rsp_granted_block == '0)
        else $error("grant reported on failed transaction");

    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_granted != '0) |-> r_res_granted <= lim)
        else $error("granted block beyond total_blocks");

    a_grant_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP_CHK && r_kind == KIND_ALLOC && map_zero.found)
        |=> r_used == $past(r_used) + FIELD_W'(1))
        else $error("used count not advanced on grant");

endmodule
